[rtl/core/node_address_pool_core_macros.svh]
// Assertion macros shared by the node address pool RTL.
`ifndef NODE_ADDRESS_POOL_CORE_MACROS_SVH
`define NODE_ADDRESS_POOL_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Hold a condition at every clock edge outside reset.
`define NAP_ASSERT_ALW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Require the consequent in the same cycle as the antecedent.
`define NAP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Require the consequent in the cycle after the antecedent.
`define NAP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define NAP_ASSERT_ALW(lbl, prop, msg)
`define NAP_ASSERT_IMP(lbl, ante, cons, msg)
`define NAP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/nap_pkg.sv]
// Types, constants and microcode program of the node address pool.
`timescale 1ns / 1ps

package nap_pkg;

	// Field widths
	localparam int ID_LOW_W  = 64;
	localparam int ID_HIGH_W = 32;
	localparam int ID_W      = ID_LOW_W + ID_HIGH_W;
	localparam int ADDR_W    = 8;
	localparam int STATUS_W  = 2;

	// Default pool size, router slot included
	localparam int POOL_ENTRIES_DEF = 16;

	// Configuration port
	localparam int PDATA_W = 64;
	localparam int PADDR_W = 5;
	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROUTER_ID_LOW  = 2'd0,
		REG_ROUTER_ID_HIGH = 2'd1,
		REG_ROUTER_ADDRESS = 2'd2
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_KNOWN = 2'd0,
		ST_NEW   = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Microcode step addresses
	typedef enum logic [2:0] {
		STEP_WAIT   = 3'd0,
		STEP_ROUTER = 3'd1,
		STEP_SCAN   = 3'd2,
		STEP_CMP    = 3'd3,
		STEP_DECIDE = 3'd4
	} step_t;

	// Jump conditions
	typedef enum logic [2:0] {
		JC_NONE       = 3'd0,
		JC_ACCEPT     = 3'd1,
		JC_ROUTER_HIT = 3'd2,
		JC_SCAN_DONE  = 3'd3,
		JC_RAM_HIT    = 3'd4,
		JC_POOL_FULL  = 3'd5
	} cond_t;

	// Result that a step emits into the output register
	typedef enum logic [2:0] {
		EM_NONE   = 3'd0,
		EM_ROUTER = 3'd1,
		EM_SLOT   = 3'd2,
		EM_NEW    = 3'd3,
		EM_FULL   = 3'd4
	} emit_t;

	typedef struct packed {
		cond_t cond;
		step_t jump_to;
		emit_t emit_taken;
		step_t next;
		emit_t emit_fall;
		logic  load_req;
		logic  slot_inc;
	} ctrl_t;

	// Control store: one word per step
	function automatic ctrl_t ucode(step_t s);
		ctrl_t w;
		w = '{cond: JC_NONE, jump_to: STEP_WAIT, emit_taken: EM_NONE,
			next: STEP_WAIT, emit_fall: EM_NONE, load_req: 1'b0, slot_inc: 1'b0};
		unique case (s)
			STEP_WAIT: begin
				w.cond     = JC_ACCEPT;
				w.jump_to  = STEP_ROUTER;
				w.next     = STEP_WAIT;
				w.load_req = 1'b1;
			end
			STEP_ROUTER: begin
				w.cond       = JC_ROUTER_HIT;
				w.jump_to    = STEP_WAIT;
				w.emit_taken = EM_ROUTER;
				w.next       = STEP_SCAN;
			end
			STEP_SCAN: begin
				w.cond    = JC_SCAN_DONE;
				w.jump_to = STEP_DECIDE;
				w.next    = STEP_CMP;
			end
			STEP_CMP: begin
				w.cond       = JC_RAM_HIT;
				w.jump_to    = STEP_WAIT;
				w.emit_taken = EM_SLOT;
				w.next       = STEP_SCAN;
				w.slot_inc   = 1'b1;
			end
			STEP_DECIDE: begin
				w.cond       = JC_POOL_FULL;
				w.jump_to    = STEP_WAIT;
				w.emit_taken = EM_FULL;
				w.next       = STEP_WAIT;
				w.emit_fall  = EM_NEW;
			end
			default: begin
				w.next = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/core/nap_req_if.sv]
// Request channel: identifier to look up or register.
`timescale 1ns / 1ps

interface nap_req_if;
	logic                           valid;
	logic                           ready;
	logic [nap_pkg::ID_LOW_W-1:0]  req_id_low;
	logic [nap_pkg::ID_HIGH_W-1:0] req_id_high;

	modport source (output valid, output req_id_low, output req_id_high, input ready);
	modport sink   (input valid, input req_id_low, input req_id_high, output ready);
endinterface

[rtl/core/nap_grant_if.sv]
// Grant channel: address and status for one request.
`timescale 1ns / 1ps

interface nap_grant_if;
	logic                          valid;
	logic                          ready;
	logic [nap_pkg::ADDR_W-1:0]   granted_address;
	logic [nap_pkg::STATUS_W-1:0] grant_status;

	modport source (output valid, output granted_address, output grant_status, input ready);
	modport sink   (input valid, input granted_address, input grant_status, output ready);
endinterface

[rtl/core/nap_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/node_address_pool_core.sv]
// Top level of the node address pool: microcoded lookup and append of node identifiers.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-----------------------------------------
//   req      | in  | valid/ready  | req_id_low[63:0], req_id_high[31:0]
//   grant    | out | valid/ready  | granted_address[7:0], grant_status[1:0]
//   apb      | in  | psel/penable | paddr[4:0], pwdata/prdata[63:0], 8-byte regs
//
// A request ends at the router compare on a router match; otherwise it scans
// the occupied client slots until a hit or the end, and then decides new or full;
// the client store has one registered read port, so each stored entry costs a
// read step and a compare step. One request is in work at a time.
// Reset leaves only the router slot occupied; no clearing pass is needed.
// A full output register stalls the sequencer at the step that emits a result.
`timescale 1ns / 1ps
`include "node_address_pool_core_macros.svh"

module node_address_pool_core #(
	parameter int POOL_ENTRIES = nap_pkg::POOL_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	nap_req_if.sink                      req,
	nap_grant_if.source                  grant,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nap_pkg::PADDR_W-1:0] paddr,
	input  logic [nap_pkg::PDATA_W-1:0] pwdata,
	output logic [nap_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	import nap_pkg::*;

	localparam int CLIENT_SLOTS = POOL_ENTRIES - 1;
	localparam int RAM_AW       = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int SLOT_W       = $clog2(POOL_ENTRIES + 1);

	// Configuration registers
	logic [ID_LOW_W-1:0]  router_id_low_q;
	logic [ID_HIGH_W-1:0] router_id_high_q;
	logic [ADDR_W-1:0]    router_address_q;
	reg_idx_t             reg_idx;
	logic                 cfg_wr;

	// Sequencer and datapath
	step_t                step_q;
	ctrl_t                cw;
	logic                 taken;
	emit_t                emit_sel;
	logic                 stall;
	logic [ID_LOW_W-1:0]  req_lo_q;
	logic [ID_HIGH_W-1:0] req_hi_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [SLOT_W-1:0]    count_q;
	logic                 router_hit;
	logic                 scan_done;
	logic                 ram_hit;
	logic                 pool_full;
	logic                 ram_wr;
	logic [ID_W-1:0]      ram_rd_data;
	logic [RAM_AW-1:0]    ram_rd_addr;
	logic [RAM_AW-1:0]    ram_wr_addr;

	// Output register
	logic                 out_valid_q;
	logic [ADDR_W-1:0]    out_addr_q;
	status_t              out_status_q;

	// Configuration port decode
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_id_low_q  <= '0;
			router_id_high_q <= '0;
			router_address_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ROUTER_ID_LOW:  router_id_low_q  <= pwdata;
				REG_ROUTER_ID_HIGH: router_id_high_q <= pwdata[ID_HIGH_W-1:0];
				REG_ROUTER_ADDRESS: router_address_q <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROUTER_ID_LOW:  prdata = router_id_low_q;
			REG_ROUTER_ID_HIGH: prdata = PDATA_W'(router_id_high_q);
			REG_ROUTER_ADDRESS: prdata = PDATA_W'(router_address_q);
			default:            prdata = '0;
		endcase
	end

	// Client identifier store
	assign ram_rd_addr = RAM_AW'(slot_q - SLOT_W'(1));
	assign ram_wr_addr = RAM_AW'(count_q - SLOT_W'(1));

	nap_ram #(
		.WIDTH (ID_W),
		.DEPTH (CLIENT_SLOTS),
		.AW    (RAM_AW)
	) u_client_ram (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (ram_wr_addr),
		.wr_data ({req_hi_q, req_lo_q}),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// Condition flags
	assign router_hit = (req_lo_q == router_id_low_q) && (req_hi_q == router_id_high_q);
	assign scan_done  = (slot_q >= count_q);
	assign ram_hit    = (ram_rd_data == {req_hi_q, req_lo_q});
	assign pool_full  = (count_q >= SLOT_W'(POOL_ENTRIES));

	// Fetch the control word and resolve the jump
	assign cw = ucode(step_q);

	always_comb begin
		unique case (cw.cond)
			JC_NONE:       taken = 1'b0;
			JC_ACCEPT:     taken = req.valid;
			JC_ROUTER_HIT: taken = router_hit;
			JC_SCAN_DONE:  taken = scan_done;
			JC_RAM_HIT:    taken = ram_hit;
			JC_POOL_FULL:  taken = pool_full;
			default:       taken = 1'b0;
		endcase
	end

	assign emit_sel = taken ? cw.emit_taken : cw.emit_fall;
	assign stall    = (emit_sel != EM_NONE) && out_valid_q && !grant.ready;
	assign ram_wr   = (emit_sel == EM_NEW) && !stall;
	assign req.ready = (step_q == STEP_WAIT);

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (!stall) begin
			step_q <= taken ? cw.jump_to : cw.next;
		end
	end

	// Capture the request while waiting
	always_ff @(posedge clk) begin
		if (cw.load_req) begin
			req_lo_q <= req.req_id_low;
			req_hi_q <= req.req_id_high;
		end
	end

	// Scan slot and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= SLOT_W'(1);
			count_q <= SLOT_W'(1);
		end else if (!stall) begin
			if (cw.load_req) begin
				slot_q <= SLOT_W'(1);
			end else if (cw.slot_inc && !taken) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (emit_sel == EM_NEW) begin
				count_q <= count_q + SLOT_W'(1);
			end
		end
	end

	// Output register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((emit_sel != EM_NONE) && !stall) begin
			out_valid_q <= 1'b1;
		end else if (grant.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			case (emit_sel)
				EM_ROUTER: begin
					out_addr_q   <= router_address_q;
					out_status_q <= ST_KNOWN;
				end
				EM_SLOT: begin
					out_addr_q   <= ADDR_W'(slot_q);
					out_status_q <= ST_KNOWN;
				end
				EM_NEW: begin
					out_addr_q   <= ADDR_W'(count_q);
					out_status_q <= ST_NEW;
				end
				EM_FULL: begin
					out_addr_q   <= '0;
					out_status_q <= ST_FULL;
				end
				default: ;
			endcase
		end
	end

	assign grant.valid           = out_valid_q;
	assign grant.granted_address = out_addr_q;
	assign grant.grant_status    = out_status_q;

	// Checks
	`NAP_ASSERT_ALW(a_count_range, (count_q >= SLOT_W'(1)) && (count_q <= SLOT_W'(POOL_ENTRIES)), "entry count out of range")
	`NAP_ASSERT_NXT(a_accept_router, req.valid && req.ready, step_q == STEP_ROUTER, "accepted request did not start with the router compare")
	`NAP_ASSERT_IMP(a_count_grows, count_q != $past(count_q), out_valid_q && (out_status_q == ST_NEW), "entry count changed without a new grant")
	`NAP_ASSERT_IMP(a_full_only, out_valid_q && (out_status_q == ST_FULL), count_q == SLOT_W'(POOL_ENTRIES), "pool full reported with free slots")
	`NAP_ASSERT_IMP(a_cmp_slot, step_q == STEP_CMP, slot_q < count_q, "compare of an unoccupied slot")

endmodule
